### rtl/hcbp_pkg.sv
// shared types and constants for the huffman code bit packer
`timescale 1ns / 1ps

package hcbp_pkg;

	localparam int SYM_W  = 8;
	localparam int LEN_W  = 6;
	localparam int CODE_W = 32;
	localparam int BYTE_W = 8;

	// request codes
	localparam logic [1:0] REQ_WRITE  = 2'd0;
	localparam logic [1:0] REQ_ENCODE = 2'd1;
	localparam logic [1:0] REQ_FLUSH  = 2'd2;

	// queue between front and back
	localparam int JOB_DEPTH = 4;
	localparam int JOB_CNT_W = 3;

	// queue in front of the result ports
	localparam int RES_DEPTH = 2;
	localparam int RES_CNT_W = 2;

	typedef struct packed {
		logic              flush;
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
	} job_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last;
	} res_t;

endpackage

### rtl/hcbp_fifo.sv
// small show-ahead queue with an occupancy count
`timescale 1ns / 1ps

module hcbp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           push_data,
	input  logic                       pop,
	output logic [WIDTH-1:0]           head,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	assign head  = store_q[rd_ptr_q];
	assign count = count_q;

endmodule

### rtl/hcbp_front.sv
// request intake: code table writes and table lookup for encode requests
`timescale 1ns / 1ps

module hcbp_front import hcbp_pkg::*; #(
	parameter int MAX_CODE_LEN = 32,
	parameter int SYMBOL_COUNT = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [1:0]           req_type,
	input  logic [SYM_W-1:0]     symbol,
	input  logic [LEN_W-1:0]     code_length,
	input  logic [CODE_W-1:0]    code_bits,
	input  logic [JOB_CNT_W-1:0] job_count,
	output logic                 job_push,
	output job_t                 job
);

	localparam int TBL_AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

	logic [LEN_W+CODE_W-1:0] tbl_mem [SYMBOL_COUNT];
	logic [LEN_W+CODE_W-1:0] entry_s1;
	logic                    valid_s1;
	logic                    flush_s1;

	logic                    accept;
	logic                    in_range;
	logic [TBL_AW-1:0]       idx;
	logic [LEN_W-1:0]        sat_len;
	logic [CODE_W:0]         mask_wide;
	logic [CODE_W-1:0]       code_masked;
	logic                    do_write;
	logic                    do_read;
	logic                    is_flush;

	assign accept   = push && !full;
	assign in_range = {1'b0, symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
	assign idx      = symbol[TBL_AW-1:0];
	assign is_flush = (req_type == REQ_FLUSH);
	assign do_write = accept && (req_type == REQ_WRITE) && in_range;
	assign do_read  = accept && (req_type == REQ_ENCODE) && in_range;

	// overlong lengths saturate, bits above the length are dropped
	assign sat_len     = (code_length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
	                                                           : code_length;
	assign mask_wide   = ((CODE_W + 1)'(1) << sat_len) - (CODE_W + 1)'(1);
	assign code_masked = code_bits & mask_wide[CODE_W-1:0];

	always_ff @(posedge clk) begin
		if (do_write) begin
			tbl_mem[idx] <= {sat_len, code_masked};
		end
		if (do_read) begin
			entry_s1 <= tbl_mem[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			flush_s1 <= 1'b0;
		end else begin
			valid_s1 <= do_read || (accept && is_flush);
			flush_s1 <= is_flush;
		end
	end

	// credit check: the stage register always drains into the job queue
	assign full = (({1'b0, job_count} + (JOB_CNT_W + 1)'(valid_s1))
	              >= (JOB_CNT_W + 1)'(JOB_DEPTH));

	assign job_push   = valid_s1;
	assign job.flush  = flush_s1;
	assign job.len    = flush_s1 ? '0 : entry_s1[LEN_W+CODE_W-1:CODE_W];
	assign job.code   = flush_s1 ? '0 : entry_s1[CODE_W-1:0];

endmodule

### rtl/hcbp_back.sv
// bit packer: appends codes to the pending bits and emits one byte a cycle while out_full is low
`timescale 1ns / 1ps

module hcbp_back import hcbp_pkg::*; #(
	parameter int MAX_CODE_LEN = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  job_t job,
	output logic job_pop,
	input  logic out_full,
	output logic out_push,
	output res_t out_res
);

	localparam int ACC_W = MAX_CODE_LEN + 7;
	localparam int TOT_W = $clog2(ACC_W + 1);

	logic [ACC_W-1:0] acc_q;
	logic [TOT_W-1:0] total_q;

	logic              emit_enc;
	logic [TOT_W-1:0]  rem;
	logic              rem_small;
	logic [BYTE_W-1:0] enc_byte;
	logic [BYTE_W-1:0] pend_mask_w;
	logic [6:0]        pend_m;
	logic [ACC_W-1:0]  load_acc;
	logic [TOT_W-1:0]  load_total;
	logic [BYTE_W-1:0] flush_byte;
	logic              do_load;
	logic              do_clear;

	assign emit_enc  = total_q >= TOT_W'(BYTE_W);
	assign rem       = emit_enc ? total_q - TOT_W'(BYTE_W) : total_q;
	assign rem_small = rem < TOT_W'(BYTE_W);
	assign enc_byte  = BYTE_W'(acc_q >> rem);

	// bits left over once the current byte is out
	assign pend_mask_w = (BYTE_W'(1) << rem[2:0]) - BYTE_W'(1);
	assign pend_m      = acc_q[6:0] & pend_mask_w[6:0];
	assign load_acc    = (ACC_W'(pend_m) << job.len) | ACC_W'(job.code);
	assign load_total  = rem + TOT_W'(job.len);
	assign flush_byte  = {pend_m, 1'b0} << (3'd7 - total_q[2:0]);

	always_comb begin
		out_push = 1'b0;
		out_res  = '0;
		job_pop  = 1'b0;
		do_load  = 1'b0;
		do_clear = 1'b0;
		if (emit_enc) begin
			if (!out_full) begin
				out_push         = 1'b1;
				out_res.out_byte = enc_byte;
				out_res.last     = rem_small;
				// load the next code alongside the final byte
				if (rem_small && job_valid && !job.flush) begin
					job_pop = 1'b1;
					do_load = 1'b1;
				end
			end
		end else if (job_valid) begin
			if (job.flush) begin
				if (total_q == '0) begin
					job_pop = 1'b1;
				end else if (!out_full) begin
					out_push         = 1'b1;
					out_res.out_byte = flush_byte;
					out_res.last     = 1'b1;
					job_pop          = 1'b1;
					do_clear         = 1'b1;
				end
			end else begin
				job_pop = 1'b1;
				do_load = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (do_load) begin
			total_q <= load_total;
		end else if (do_clear) begin
			total_q <= '0;
		end else if (out_push) begin
			total_q <= rem;
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			acc_q <= load_acc;
		end
	end

endmodule

### rtl/huffman_code_bit_packer_core.sv
// top level of the huffman code bit packer
// encode path: lookup stage register, job queue, packer, result queue, then the result ports
// the packer emits one result byte per cycle while the result queue has room
// table writes and flushes are taken at the intake; the byte packer sets the pace
// reset: arst_n low clears the pending bits and all queues; code table contents stay undefined
`timescale 1ns / 1ps

module huffman_code_bit_packer_core import hcbp_pkg::*; #(
	parameter int MAX_CODE_LEN = 32,
	parameter int SYMBOL_COUNT = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	// request side
	input  logic              push,
	output logic              full,
	input  logic [1:0]        req_type,
	input  logic [SYM_W-1:0]  symbol,
	input  logic [LEN_W-1:0]  code_length,
	input  logic [CODE_W-1:0] code_bits,
	// result side
	output logic              empty,
	input  logic              pop,
	output logic [BYTE_W-1:0] out_byte,
	output logic              last
);

	// front to job queue
	logic                 job_push;
	job_t                 job_in;
	logic [JOB_CNT_W-1:0] job_count;

	// job queue to back
	job_t                 job_head;
	logic                 job_valid;
	logic                 job_pop;

	// back to result queue
	logic                 res_push;
	res_t                 res_in;
	res_t                 res_head;
	logic [RES_CNT_W-1:0] res_count;
	logic                 res_full;
	logic                 res_pop;

	// intake: table writes and table lookups for encode requests
	hcbp_front #(
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.SYMBOL_COUNT (SYMBOL_COUNT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.req_type    (req_type),
		.symbol      (symbol),
		.code_length (code_length),
		.code_bits   (code_bits),
		.job_count   (job_count),
		.job_push    (job_push),
		.job         (job_in)
	);

	// decouples lookup from packing so each side can stall on its own
	hcbp_fifo #(
		.WIDTH ($bits(job_t)),
		.DEPTH (JOB_DEPTH)
	) u_job_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.pop       (job_pop),
		.head      (job_head),
		.count     (job_count)
	);

	assign job_valid = (job_count != '0);

	// packer: one byte a cycle into the result queue while it has room
	hcbp_back #(
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job_head),
		.job_pop   (job_pop),
		.out_full  (res_full),
		.out_push  (res_push),
		.out_res   (res_in)
	);

	// result queue keeps the packer running while a byte waits to be taken
	hcbp_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_in),
		.pop       (res_pop),
		.head      (res_head),
		.count     (res_count)
	);

	assign res_full = (res_count == RES_CNT_W'(RES_DEPTH));
	assign empty    = (res_count == '0);
	assign res_pop  = pop && !empty;
	assign out_byte = res_head.out_byte;
	assign last     = res_head.last;

	// job queue never overflows thanks to the credit check in the front
	a_job_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> (job_count != JOB_CNT_W'(JOB_DEPTH)) || job_pop)
		else $error("job queue overflow");

	// packer only pops a job that is there
	a_job_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid)
		else $error("job queue underflow");

	// packer never writes into a full result queue
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result queue overflow");

	// while the intake reports full the job queue plus stage hold no free slot
	a_full_means_busy: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> (job_count != '0))
		else $error("intake full with empty job queue");

endmodule

### verif/tb.sv
// testbench for the huffman code bit packer: directed table, random requests, predictor check
`timescale 1ns / 1ps

module tb;
	import hcbp_pkg::*;

	// request code that the block drops without a result
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam int MAX_LEN      = 32;
	localparam int RAND_ITEMS   = 320;
	localparam int DRAIN_CYCLES = 32;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int REPORT_MAX   = 10;

	// one row of the directed table; typed rows carry their bytes, first byte in res[0]
	typedef struct packed {
		logic [1:0]        rq;
		logic [7:0]        sym;
		logic [5:0]        len;
		logic [31:0]       bits;
		logic              typed;
		logic [2:0]        n_res;
		logic [0:3][7:0]   res;
	} dir_row_t;

	// one packed output byte as the result side should see it
	typedef struct packed {
		logic [7:0] byte_val;
		logic       last;
	} packed_byte_t;

	localparam int DIR_ROWS = 24;

	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		// flush right after reset, nothing pending
		'{REQ_FLUSH,  8'h00, 6'd0,  32'h0000_0000, 1'b1, 3'd0, 32'h0000_0000},
		// unused request code with every field at its top
		'{REQ_UNUSED, 8'hFF, 6'd63, 32'hFFFF_FFFF, 1'b1, 3'd0, 32'h0000_0000},
		'{REQ_WRITE,  8'h00, 6'd8,  32'h0000_00A5, 1'b1, 3'd0, 32'h0000_0000},
		'{REQ_ENCODE, 8'h00, 6'd0,  32'h0000_0000, 1'b1, 3'd1, 32'hA500_0000},
		// longest code, all ones, four bytes out
		'{REQ_WRITE,  8'hFF, 6'd32, 32'hFFFF_FFFF, 1'b1, 3'd0, 32'h0000_0000},
		'{REQ_ENCODE, 8'hFF, 6'd0,  32'h0000_0000, 1'b1, 3'd4, 32'hFFFF_FFFF},
		// zero-length code stays silent
		'{REQ_WRITE,  8'h01, 6'd0,  32'hDEAD_BEEF, 1'b1, 3'd0, 32'h0000_0000},
		'{REQ_ENCODE, 8'h01, 6'd0,  32'h0000_0000, 1'b1, 3'd0, 32'h0000_0000},
		// overlong length saturates to the maximum
		'{REQ_WRITE,  8'h02, 6'd63, 32'h8000_0001, 1'b1, 3'd0, 32'h0000_0000},
		'{REQ_ENCODE, 8'h02, 6'd0,  32'h0000_0000, 1'b1, 3'd4, 32'h8000_0001},
		// code bits above the length are dropped: 3'b101 kept
		'{REQ_WRITE,  8'h03, 6'd3,  32'hFFFF_FFFD, 1'b1, 3'd0, 32'h0000_0000},
		'{REQ_ENCODE, 8'h03, 6'd0,  32'h0000_0000, 1'b1, 3'd0, 32'h0000_0000},
		'{REQ_FLUSH,  8'h00, 6'd0,  32'h0000_0000, 1'b1, 3'd1, 32'hA000_0000},
		'{REQ_FLUSH,  8'h00, 6'd0,  32'h0000_0000, 1'b1, 3'd0, 32'h0000_0000},
		'{REQ_WRITE,  8'h04, 6'd1,  32'h0000_0001, 1'b1, 3'd0, 32'h0000_0000},
		// build up seven pending bits, then a long code on top
		'{REQ_ENCODE, 8'h03, 6'd0,  32'h0000_0000, 1'b0, 3'd0, 32'h0000_0000},
		'{REQ_ENCODE, 8'h03, 6'd0,  32'h0000_0000, 1'b0, 3'd0, 32'h0000_0000},
		'{REQ_ENCODE, 8'h04, 6'd0,  32'h0000_0000, 1'b0, 3'd0, 32'h0000_0000},
		'{REQ_ENCODE, 8'hFF, 6'd0,  32'h0000_0000, 1'b0, 3'd0, 32'h0000_0000},
		'{REQ_FLUSH,  8'h00, 6'd0,  32'h0000_0000, 1'b0, 3'd0, 32'h0000_0000},
		// length 33 saturates, code all zeros
		'{REQ_WRITE,  8'h05, 6'd33, 32'h0000_0000, 1'b1, 3'd0, 32'h0000_0000},
		'{REQ_ENCODE, 8'h04, 6'd0,  32'h0000_0000, 1'b0, 3'd0, 32'h0000_0000},
		'{REQ_ENCODE, 8'h05, 6'd0,  32'h0000_0000, 1'b0, 3'd0, 32'h0000_0000},
		// flush of a single zero bit gives a zero byte
		'{REQ_FLUSH,  8'h00, 6'd0,  32'h0000_0000, 1'b0, 3'd0, 32'h0000_0000}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  req_type;
	logic [7:0]  symbol;
	logic [5:0]  code_length;
	logic [31:0] code_bits;
	logic        empty;
	logic        pop;
	logic [7:0]  out_byte;
	logic        last;

	// predictor state: code table and the partial byte still held back
	logic [5:0]  tbl_len [256];
	logic [31:0] tbl_code [256];
	bit          tbl_written [256];
	logic [7:0]  known_syms [$];
	logic [6:0]  held_bits;
	logic [2:0]  held_cnt;

	// bytes still owed by the block, newest at the front, oldest at the back
	packed_byte_t exp_bytes_q [$];

	int mismatch_cnt = 0;
	int sent_cnt = 0;
	int taken_cnt = 0;
	int cycle_cnt = 0;

	huffman_code_bit_packer_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.req_type    (req_type),
		.symbol      (symbol),
		.code_length (code_length),
		.code_bits   (code_bits),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.last        (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// every third stretch of 32 handshakes runs back to back, the rest idle at random
	function automatic int draw_gap(input int hs_no);
		if ((hs_no / 32) % 3 == 1)
			return 0;
		return $urandom_range(0, 14);
	endfunction

	// applies one accepted request to the predictor, returns how many bytes it releases
	function automatic int pack_request(input logic [1:0] rq, input logic [7:0] sym,
			input logic [5:0] len, input logic [31:0] bits,
			output logic [0:3][7:0] bytes_out);
		logic [63:0] acc;
		logic [63:0] keep_mask;
		logic [5:0]  sat_len;
		int          clen;
		int          total;
		int          n;
		n = 0;
		bytes_out = '0;
		case (rq)
			REQ_WRITE: begin
				sat_len = (len > MAX_LEN) ? 6'(MAX_LEN) : len;
				keep_mask = (64'd1 << sat_len) - 64'd1;
				tbl_len[sym] = sat_len;
				tbl_code[sym] = bits & keep_mask[31:0];
				if (!tbl_written[sym])
					known_syms.push_front(sym);
				tbl_written[sym] = 1'b1;
			end
			REQ_ENCODE: begin
				clen = int'(tbl_len[sym]);
				if (clen != 0) begin
					// held bits go first, code follows msb first
					acc = ({57'd0, held_bits} << clen) | {32'd0, tbl_code[sym]};
					total = int'(held_cnt) + clen;
					while (total >= 8) begin
						total -= 8;
						bytes_out[n] = 8'(acc >> total);
						n++;
					end
					held_bits = 7'(acc & ((64'd1 << total) - 64'd1));
					held_cnt = 3'(total);
				end
			end
			REQ_FLUSH: begin
				if (held_cnt != 0) begin
					// pad the partial byte with zeros at the low end
					bytes_out[0] = 8'({1'b0, held_bits} << (8 - int'(held_cnt)));
					n = 1;
					held_bits = '0;
					held_cnt = '0;
				end
			end
			default: ;
		endcase
		return n;
	endfunction

	function automatic void queue_bytes(input int n, input logic [0:3][7:0] quad);
		for (int k = 0; k < n; k++)
			exp_bytes_q.push_front('{byte_val: quad[k], last: (k == n - 1)});
	endfunction

	// holds one request on the ports until the block takes it
	task automatic send_request(input logic [1:0] rq, input logic [7:0] sym,
			input logic [5:0] len, input logic [31:0] bits);
		int gap;
		gap = draw_gap(sent_cnt);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		req_type <= rq;
		symbol <= sym;
		code_length <= len;
		code_bits <= bits;
		do @(posedge clk); while (full);
		sent_cnt++;
	endtask

	// random table write: mostly short codes, some long, a few empty or overlong
	task automatic random_write();
		logic [5:0] len;
		int         pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			len = 6'd0;
		else if (pick == 1)
			len = 6'($urandom_range(33, 63));
		else if (pick < 7)
			len = 6'($urandom_range(25, 32));
		else
			len = 6'($urandom_range(1, 12));
		send_request(REQ_WRITE, 8'($urandom_range(0, 255)), len, $urandom);
	endtask

	// request side: reset, directed table, then random traffic
	initial begin : request_side
		logic [0:3][7:0] quad;
		int              n;
		int              idx;
		int              done;
		int              pick;
		arst_n = 1'b0;
		push = 1'b0;
		req_type = REQ_WRITE;
		symbol = '0;
		code_length = '0;
		code_bits = '0;
		held_bits = '0;
		held_cnt = '0;
		for (idx = 0; idx < 256; idx++)
			tbl_written[idx] = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (idx = 0; idx < DIR_ROWS; idx++) begin
			send_request(DIR_TABLE[idx].rq, DIR_TABLE[idx].sym, DIR_TABLE[idx].len,
				DIR_TABLE[idx].bits);
			n = pack_request(DIR_TABLE[idx].rq, DIR_TABLE[idx].sym, DIR_TABLE[idx].len,
				DIR_TABLE[idx].bits, quad);
			// typed rows carry their own bytes; the predictor only keeps its state in step
			if (DIR_TABLE[idx].typed)
				queue_bytes(int'(DIR_TABLE[idx].n_res), DIR_TABLE[idx].res);
			else
				queue_bytes(n, quad);
		end

		// random part: mostly encodes of written symbols, with writes and flushes mixed in
		done = 0;
		while (done < RAND_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				// unused code, ignored by the block, not counted
				send_request(REQ_UNUSED, 8'($urandom), 6'($urandom), $urandom);
				n = pack_request(REQ_UNUSED, symbol, code_length, code_bits, quad);
			end else begin
				if (pick < 18)
					random_write();
				else if (pick < 26)
					send_request(REQ_FLUSH, 8'($urandom), 6'($urandom), $urandom);
				else
					send_request(REQ_ENCODE,
						known_syms[$urandom_range(0, known_syms.size() - 1)],
						6'($urandom), $urandom);
				done++;
			end
			if (pick >= 4) begin
				n = pack_request(req_type, symbol, code_length, code_bits, quad);
				queue_bytes(n, quad);
			end
		end
		push <= 1'b0;

		// drain, then give a stray byte time to show up
		while (exp_bytes_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && exp_bytes_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// result side: pops with random stalls and checks every byte against the oldest expectation
	initial begin : result_side
		packed_byte_t want;
		int           gap;
		pop = 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			gap = draw_gap(taken_cnt);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			taken_cnt++;
			if (exp_bytes_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= REPORT_MAX)
					$display("unexpected byte %02h last %0b", out_byte, last);
			end else begin
				want = exp_bytes_q.pop_back();
				if (out_byte !== want.byte_val || last !== want.last) begin
					mismatch_cnt++;
					if (mismatch_cnt <= REPORT_MAX)
						$display("byte %0d: expected %02h last %0b, got %02h last %0b",
							taken_cnt, want.byte_val, want.last, out_byte, last);
				end
			end
		end
	end

endmodule
